FILE: design/wfnp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfnp_pkg
// Shared codes and sizes for the window filtered nearest point search.
// ----------------------------------------------------------------------------
package wfnp_pkg;

  localparam int DEF_MAX_POINTS = 1024;
  localparam int DEF_COORD_BITS = 24;

  localparam int CMD_BITS    = 2;
  localparam int STATUS_BITS = 3;
  localparam int DIST_BITS   = 50;
  localparam int REJ_BITS    = 16;
  localparam int REG_BITS    = 2;

  localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_QUERY = 2'd2;

  localparam logic [REG_BITS-1:0] REG_WEST  = 2'd0;
  localparam logic [REG_BITS-1:0] REG_EAST  = 2'd1;
  localparam logic [REG_BITS-1:0] REG_SOUTH = 2'd2;
  localparam logic [REG_BITS-1:0] REG_NORTH = 2'd3;

  localparam logic [STATUS_BITS-1:0] ST_STORED  = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_OUTSIDE = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_FOUND   = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY   = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_CLEARED = 3'd5;

endpackage

FILE: design/wfnp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfnp_ram
// Generic simple dual port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module wfnp_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/wfnp_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfnp_dist
// Pipelined squared distance unit: absolute differences, squares, then a
// saturating sum. Carries the point index and coordinates alongside.
// ----------------------------------------------------------------------------
module wfnp_dist
  import wfnp_pkg::*;
#(
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int TAG_BITS   = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [TAG_BITS-1:0]          in_tag,
  input  logic signed [COORD_BITS-1:0] pick_east,
  input  logic signed [COORD_BITS-1:0] pick_north,
  input  logic signed [COORD_BITS-1:0] pt_east,
  input  logic signed [COORD_BITS-1:0] pt_north,
  output logic                         out_valid,
  output logic [TAG_BITS-1:0]          out_tag,
  output logic signed [COORD_BITS-1:0] out_east,
  output logic signed [COORD_BITS-1:0] out_north,
  output logic [DIST_BITS-1:0]         out_dist
);

  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int SUM_W = SQ_W + 1;
  localparam int EXT_W = (SUM_W > DIST_BITS) ? SUM_W : DIST_BITS;

  logic signed [COORD_BITS:0] diff_e;
  logic signed [COORD_BITS:0] diff_n;
  logic [COORD_BITS:0]        abs_e;
  logic [COORD_BITS:0]        abs_n;
  logic [SUM_W-1:0]           sum;
  logic [EXT_W-1:0]           sum_ext;
  logic [EXT_W-1:0]           dist_max_ext;

  logic [2:0]                  vld;
  logic [TAG_BITS-1:0]         tag1, tag2;
  logic signed [COORD_BITS-1:0] e1, n1, e2, n2;
  logic [COORD_BITS-1:0]       mag_e, mag_n;
  logic [SQ_W-1:0]             sq_e, sq_n;

  assign diff_e = {pick_east[COORD_BITS-1], pick_east} - {pt_east[COORD_BITS-1], pt_east};
  assign diff_n = {pick_north[COORD_BITS-1], pick_north} - {pt_north[COORD_BITS-1], pt_north};
  assign abs_e  = diff_e[COORD_BITS] ? (~diff_e + 1'b1) : diff_e;
  assign abs_n  = diff_n[COORD_BITS] ? (~diff_n + 1'b1) : diff_n;

  assign sum          = SUM_W'(sq_e) + SUM_W'(sq_n);
  assign sum_ext      = EXT_W'(sum);
  assign dist_max_ext = EXT_W'({DIST_BITS{1'b1}});

  assign out_valid = vld[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[1:0], in_valid};
    end
    // stage 1: absolute differences
    mag_e <= abs_e[COORD_BITS-1:0];
    mag_n <= abs_n[COORD_BITS-1:0];
    tag1  <= in_tag;
    e1    <= pt_east;
    n1    <= pt_north;
    // stage 2: squares
    sq_e  <= SQ_W'(mag_e) * SQ_W'(mag_e);
    sq_n  <= SQ_W'(mag_n) * SQ_W'(mag_n);
    tag2  <= tag1;
    e2    <= e1;
    n2    <= n1;
    // stage 3: saturating sum
    out_dist  <= (sum_ext > dist_max_ext) ? {DIST_BITS{1'b1}} : sum_ext[DIST_BITS-1:0];
    out_tag   <= tag2;
    out_east  <= e2;
    out_north <= n2;
  end

endmodule

FILE: design/window_filtered_nearest_point_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_filtered_nearest_point_top
// Point store with window filter on load and brute force nearest search.
//
// Input words (cmd, coord_east, coord_north) are taken when in_valid is high
// and in_stall low; each word except the unused command code gives one
// result word on the out_* ports, taken when out_valid is high and out_stall
// low. For clear and load the result is registered and shows the next
// cycle. A query reads one stored point per cycle from the point RAM into a
// four stage pipeline (RAM read, differences, squares, sum) and a compare
// against the running best; an empty store answers without a scan. Only one
// word is in work at a time: in_stall is high during a query scan and while
// a finished result is held by out_stall. The window registers are written
// through cfg_we / cfg_addr / cfg_data; the user must write them only while
// the block is idle, the block itself does not enforce this.
// Synchronous reset sets the window to the full coordinate range, empties
// the store and zeroes the outside count; no clearing pass is needed.
// ----------------------------------------------------------------------------
module window_filtered_nearest_point_top
  import wfnp_pkg::*;
#(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [REG_BITS-1:0]                  cfg_addr,
  input  logic [COORD_BITS-1:0]                cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [CMD_BITS-1:0]                  cmd,
  input  logic signed [COORD_BITS-1:0]         coord_east,
  input  logic signed [COORD_BITS-1:0]         coord_north,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [STATUS_BITS-1:0]               status,
  output logic [$clog2(MAX_POINTS)-1:0]        nearest_index,
  output logic signed [COORD_BITS-1:0]         nearest_east,
  output logic signed [COORD_BITS-1:0]         nearest_north,
  output logic [DIST_BITS-1:0]                 nearest_dist_sq,
  output logic [$clog2(MAX_POINTS+1)-1:0]      stored_count,
  output logic [REJ_BITS-1:0]                  outside_count
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t state;

  logic signed [COORD_BITS-1:0] window_west, window_east, window_south, window_north;
  logic [CNT_W-1:0]             point_count;
  logic [REJ_BITS-1:0]          rejected_count;

  logic signed [COORD_BITS-1:0] pick_east, pick_north;
  logic [IDX_W-1:0]             rd_addr, last_idx;
  logic                         issuing;
  logic                         ram_valid;
  logic [IDX_W-1:0]             ram_tag;
  logic [2*COORD_BITS-1:0]      ram_rdata;

  logic                         d_valid;
  logic [IDX_W-1:0]             d_tag;
  logic signed [COORD_BITS-1:0] d_east, d_north;
  logic [DIST_BITS-1:0]         d_dist;

  logic [IDX_W-1:0]             best_idx;
  logic signed [COORD_BITS-1:0] best_east, best_north;
  logic [DIST_BITS-1:0]         best_dist;

  logic             out_free, accept, in_window, full, store_we;
  logic [CNT_W-1:0] count_m1;
  logic             take_best;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !(state == S_IDLE && out_free);
  assign accept   = in_valid && !in_stall;

  assign in_window = (coord_east >= window_west) && (coord_east <= window_east) &&
                     (coord_north >= window_south) && (coord_north <= window_north);
  assign full     = point_count >= CNT_W'(MAX_POINTS);
  assign store_we = accept && (cmd == CMD_LOAD) && in_window && !full;
  assign count_m1 = point_count - CNT_W'(1);

  assign take_best = d_valid && ((d_tag == '0) || (d_dist < best_dist));

  wfnp_ram #(
    .WIDTH (2 * COORD_BITS),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (point_count[IDX_W-1:0]),
    .wdata ({coord_east, coord_north}),
    .re    (issuing),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  wfnp_dist #(
    .COORD_BITS (COORD_BITS),
    .TAG_BITS   (IDX_W)
  ) u_dist (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (ram_valid),
    .in_tag     (ram_tag),
    .pick_east  (pick_east),
    .pick_north (pick_north),
    .pt_east    (ram_rdata[2*COORD_BITS-1:COORD_BITS]),
    .pt_north   (ram_rdata[COORD_BITS-1:0]),
    .out_valid  (d_valid),
    .out_tag    (d_tag),
    .out_east   (d_east),
    .out_north  (d_north),
    .out_dist   (d_dist)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      issuing        <= 1'b0;
      ram_valid      <= 1'b0;
      point_count    <= '0;
      rejected_count <= '0;
      window_west    <= {1'b1, {(COORD_BITS-1){1'b0}}};
      window_east    <= {1'b0, {(COORD_BITS-1){1'b1}}};
      window_south   <= {1'b1, {(COORD_BITS-1){1'b0}}};
      window_north   <= {1'b0, {(COORD_BITS-1){1'b1}}};
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_WEST:  window_west  <= cfg_data;
          REG_EAST:  window_east  <= cfg_data;
          REG_SOUTH: window_south <= cfg_data;
          REG_NORTH: window_north <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      ram_valid <= issuing;
      ram_tag   <= rd_addr;

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            nearest_index   <= '0;
            nearest_east    <= '0;
            nearest_north   <= '0;
            nearest_dist_sq <= '0;
            stored_count    <= point_count;
            outside_count   <= rejected_count;
            unique case (cmd)
              CMD_CLEAR: begin
                point_count    <= '0;
                rejected_count <= '0;
                status         <= ST_CLEARED;
                stored_count   <= '0;
                outside_count  <= '0;
                out_valid      <= 1'b1;
              end
              CMD_LOAD: begin
                out_valid <= 1'b1;
                if (!in_window) begin
                  status <= ST_OUTSIDE;
                  if (rejected_count != '1) begin
                    rejected_count <= rejected_count + REJ_BITS'(1);
                    outside_count  <= rejected_count + REJ_BITS'(1);
                  end
                end else if (full) begin
                  status <= ST_FULL;
                end else begin
                  status       <= ST_STORED;
                  point_count  <= point_count + CNT_W'(1);
                  stored_count <= point_count + CNT_W'(1);
                end
              end
              CMD_QUERY: begin
                if (point_count == '0) begin
                  status    <= ST_EMPTY;
                  out_valid <= 1'b1;
                end else begin
                  pick_east  <= coord_east;
                  pick_north <= coord_north;
                  rd_addr    <= '0;
                  last_idx   <= count_m1[IDX_W-1:0];
                  issuing    <= 1'b1;
                  state      <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (issuing) begin
            if (rd_addr == last_idx) begin
              issuing <= 1'b0;
            end else begin
              rd_addr <= rd_addr + IDX_W'(1);
            end
          end
          if (take_best) begin
            best_idx   <= d_tag;
            best_east  <= d_east;
            best_north <= d_north;
            best_dist  <= d_dist;
          end
          if (d_valid && (d_tag == last_idx)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            status          <= ST_FOUND;
            nearest_index   <= best_idx;
            nearest_east    <= best_east;
            nearest_north   <= best_north;
            nearest_dist_sq <= best_dist;
            stored_count    <= point_count;
            outside_count   <= rejected_count;
            out_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
